/* sv/ftr_pkg.sv */
package ftr_pkg;

  // Number of fan lanes that the result word always carries.
  localparam int MAX_FANS = 5;
  localparam int DEF_FAN_COUNT = 5;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [6:0]  RST_FAILSAFE_PERCENT = 7'd40;
  localparam logic [15:0] RST_TIMEOUT_MS       = 16'd5000;
  localparam logic [15:0] RST_WINDOW_MS        = 16'd1000;
  localparam logic [7:0]  RST_RPM_PER_PULSE    = 8'd30;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam logic [7:0]  PCT_MAX = 8'd100;
  localparam logic [7:0]  PCT_MIN = 8'd1;

  // 255 / 100 as a fixed-point reciprocal with 21 fraction bits; exact for
  // every 7-bit percent.
  localparam logic [29:0] DUTY_RECIP = 30'd5347860;
  localparam int          DUTY_SHIFT = 21;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_TACH = 2'd1,
    OP_CMD  = 2'd2,
    OP_IDLE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_FAILSAFE_PERCENT = 2'd0,
    REG_TIMEOUT_MS       = 2'd1,
    REG_WINDOW_MS        = 2'd2,
    REG_RPM_PER_PULSE    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [6:0]  failsafe_percent;
    logic [15:0] timeout_ms;
    logic [15:0] window_ms;
    logic [7:0]  rpm_per_pulse;
  } cfg_t;

  typedef struct packed {
    op_t        opcode;
    logic [4:0] edge_mask;
    logic [7:0] speed_percent;
  } item_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       failsafe_active;
    logic       timeout_event;
    logic       report_valid;
  } wdog_res_t;

  function automatic logic [7:0] percent_to_duty(input logic [6:0] pct);
    logic [29:0] prod;
    logic [8:0]  q;
    prod = 30'(pct) * DUTY_RECIP;
    q = prod[29:DUTY_SHIFT];
    return (q > 9'd255) ? 8'hFF : q[7:0];
  endfunction

endpackage

/* sv/ftr_in_if.sv */
interface ftr_in_if;
  import ftr_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [4:0] edge_mask;
  logic [7:0] speed_percent;

  modport source (output valid, opcode, edge_mask, speed_percent, input ready);
  modport sink (input valid, opcode, edge_mask, speed_percent, output ready);
endinterface

/* sv/ftr_out_if.sv */
interface ftr_out_if;
  import ftr_pkg::*;

  logic        valid;
  logic        ready;
  logic [7:0]  duty;
  logic        failsafe_active;
  logic        timeout_event;
  logic        report_valid;
  logic [15:0] rpm_fan0;
  logic [15:0] rpm_fan1;
  logic [15:0] rpm_fan2;
  logic [15:0] rpm_fan3;
  logic [15:0] rpm_fan4;

  modport source (
    output valid, duty, failsafe_active, timeout_event, report_valid,
           rpm_fan0, rpm_fan1, rpm_fan2, rpm_fan3, rpm_fan4,
    input  ready
  );
  modport sink (
    input  valid, duty, failsafe_active, timeout_event, report_valid,
           rpm_fan0, rpm_fan1, rpm_fan2, rpm_fan3, rpm_fan4,
    output ready
  );
endinterface

/* sv/ftr_regs.sv */
module ftr_regs
  import ftr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.failsafe_percent <= RST_FAILSAFE_PERCENT;
      cfg.timeout_ms       <= RST_TIMEOUT_MS;
      cfg.window_ms        <= RST_WINDOW_MS;
      cfg.rpm_per_pulse    <= RST_RPM_PER_PULSE;
    end else if (wr_en) begin
      unique case (idx)
        REG_FAILSAFE_PERCENT: cfg.failsafe_percent <= pwdata[6:0];
        REG_TIMEOUT_MS:       cfg.timeout_ms       <= pwdata[15:0];
        REG_WINDOW_MS:        cfg.window_ms        <= pwdata[15:0];
        REG_RPM_PER_PULSE:    cfg.rpm_per_pulse    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FAILSAFE_PERCENT: prdata = DATA_W'(cfg.failsafe_percent);
      REG_TIMEOUT_MS:       prdata = DATA_W'(cfg.timeout_ms);
      REG_WINDOW_MS:        prdata = DATA_W'(cfg.window_ms);
      REG_RPM_PER_PULSE:    prdata = DATA_W'(cfg.rpm_per_pulse);
      default:              prdata = '0;
    endcase
  end

endmodule

/* sv/ftr_tach.sv */
module ftr_tach
  import ftr_pkg::*;
#(
  parameter int FAN_COUNT = DEF_FAN_COUNT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  item_t                      word,
  input  cfg_t                       cfg,
  output logic [FAN_COUNT-1:0][15:0] rpm_next
);

  logic [FAN_COUNT-1:0][15:0] pulse_counts;
  logic [FAN_COUNT-1:0][15:0] pulse_counts_next;
  logic [FAN_COUNT-1:0][15:0] latched_rpm;
  logic [15:0]                window_elapsed;
  logic [15:0]                window_elapsed_next;
  logic [15:0]                window_inc;
  logic                       is_tick;
  logic                       is_tach;
  logic                       window_done;

  assign is_tick     = (word.opcode == OP_TICK);
  assign is_tach     = (word.opcode == OP_TACH);
  assign window_inc  = (window_elapsed != CNT_MAX) ? window_elapsed + 16'd1 : window_elapsed;
  assign window_done = is_tick && (window_inc >= cfg.window_ms);

  always_comb begin
    if (window_done) begin
      window_elapsed_next = '0;
    end else if (is_tick) begin
      window_elapsed_next = window_inc;
    end else begin
      window_elapsed_next = window_elapsed;
    end
  end

  for (genvar i = 0; i < FAN_COUNT; i++) begin : g_lane
    logic [23:0] prod;
    logic [15:0] rpm_sat;

    assign prod    = pulse_counts[i] * cfg.rpm_per_pulse;
    assign rpm_sat = (prod[23:16] != 8'd0) ? CNT_MAX : prod[15:0];

    always_comb begin
      if (window_done) begin
        pulse_counts_next[i] = '0;
      end else if (is_tach && word.edge_mask[i] && pulse_counts[i] != CNT_MAX) begin
        pulse_counts_next[i] = pulse_counts[i] + 16'd1;
      end else begin
        pulse_counts_next[i] = pulse_counts[i];
      end
    end

    assign rpm_next[i] = window_done ? rpm_sat : latched_rpm[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_counts   <= '0;
      latched_rpm    <= '0;
      window_elapsed <= '0;
    end else if (step) begin
      pulse_counts   <= pulse_counts_next;
      latched_rpm    <= rpm_next;
      window_elapsed <= window_elapsed_next;
    end
  end

endmodule

/* sv/ftr_wdog.sv */
module ftr_wdog
  import ftr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  item_t     word,
  input  cfg_t      cfg,
  output wdog_res_t res_next
);

  logic [15:0] since_command;
  logic [15:0] since_command_next;
  logic [16:0] since_inc;
  logic        in_failsafe;
  logic [7:0]  duty_value;
  logic        cmd_ok;

  assign since_inc = {1'b0, since_command} + 17'd1;
  assign cmd_ok    = (word.opcode == OP_CMD) && (word.speed_percent >= PCT_MIN)
                     && (word.speed_percent <= PCT_MAX);

  always_comb begin
    res_next.duty            = duty_value;
    res_next.failsafe_active = in_failsafe;
    res_next.timeout_event   = 1'b0;
    res_next.report_valid    = 1'b0;
    since_command_next       = since_command;
    unique case (word.opcode)
      OP_TICK: begin
        since_command_next = since_inc[16] ? CNT_MAX : since_inc[15:0];
        // The timeout compares against the count before it saturates.
        if (!in_failsafe && since_inc > {1'b0, cfg.timeout_ms}) begin
          res_next.failsafe_active = 1'b1;
          res_next.duty            = percent_to_duty(cfg.failsafe_percent);
          res_next.timeout_event   = 1'b1;
        end
      end
      OP_CMD: begin
        if (cmd_ok) begin
          res_next.duty            = percent_to_duty(word.speed_percent[6:0]);
          res_next.failsafe_active = 1'b0;
          res_next.report_valid    = 1'b1;
          since_command_next       = '0;
        end
      end
      OP_TACH, OP_IDLE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_command <= '0;
      in_failsafe   <= 1'b1;
      duty_value    <= percent_to_duty(RST_FAILSAFE_PERCENT);
    end else if (step) begin
      since_command <= since_command_next;
      in_failsafe   <= res_next.failsafe_active;
      duty_value    <= res_next.duty;
    end
  end

endmodule

/* sv/fan_tach_rpm_and_failsafe_pwm.sv */
// Fan tachometer and PWM watchdog. Each accepted word (millisecond tick, tach
// edge mask or speed command) yields exactly one result word carrying the
// current duty, failsafe status, timeout and report flags and the latched RPM
// of every fan. The block takes one word per clock while the result channel
// is not stalled: a word sits in an input register while the pulse counters,
// window counter, watchdog and duty are updated, and the result lands in an
// output register and is held there until the sink is ready. Back-pressure on
// the result channel stalls the input only once the input register is full.
// Configuration is written through the APB port at byte offsets 0
// (failsafe_percent), 4 (timeout_ms), 8 (window_ms) and 12 (rpm_per_pulse);
// the user must write it only while no word is in flight, which the block
// does not enforce. Fans at or above FAN_COUNT always read zero.
module fan_tach_rpm_and_failsafe_pwm
  import ftr_pkg::*;
#(
  parameter int FAN_COUNT = DEF_FAN_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  ftr_in_if.sink            item,
  ftr_out_if.source         result
);

  cfg_t                       cfg;
  logic                       in_valid;
  item_t                      in_word;
  logic                       step;
  logic                       out_valid;
  wdog_res_t                  res_next;
  wdog_res_t                  res;
  logic [FAN_COUNT-1:0][15:0] rpm_next;
  logic [MAX_FANS-1:0][15:0]  rpm_wide;
  logic [MAX_FANS-1:0][15:0]  rpm_out;

  ftr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The word in the input register is processed when the output register
  // is free or is being emptied in this cycle.
  assign step       = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_word.opcode        <= op_t'(item.opcode);
      in_word.edge_mask     <= item.edge_mask;
      in_word.speed_percent <= item.speed_percent;
    end
  end

  ftr_tach #(
    .FAN_COUNT (FAN_COUNT)
  ) u_tach (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .word     (in_word),
    .cfg      (cfg),
    .rpm_next (rpm_next)
  );

  ftr_wdog u_wdog (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .word     (in_word),
    .cfg      (cfg),
    .res_next (res_next)
  );

  for (genvar i = 0; i < MAX_FANS; i++) begin : g_rpm
    if (i < FAN_COUNT) begin : g_used
      assign rpm_wide[i] = rpm_next[i];
    end else begin : g_unused
      assign rpm_wide[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res     <= res_next;
      rpm_out <= rpm_wide;
    end
  end

  assign result.valid           = out_valid;
  assign result.duty            = res.duty;
  assign result.failsafe_active = res.failsafe_active;
  assign result.timeout_event   = res.timeout_event;
  assign result.report_valid    = res.report_valid;
  assign result.rpm_fan0        = rpm_out[0];
  assign result.rpm_fan1        = rpm_out[1];
  assign result.rpm_fan2        = rpm_out[2];
  assign result.rpm_fan3        = rpm_out[3];
  assign result.rpm_fan4        = rpm_out[4];

endmodule

/* tb/ftr_status_check.sv */
`timescale 1ns / 100ps
module ftr_status_check
  import ftr_pkg::*;
#(
  parameter int FAN_COUNT = DEF_FAN_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  ftr_in_if                 item,
  ftr_out_if                result,
  output int                mismatches,
  output int                in_flight
);

  localparam int LANES = (FAN_COUNT > MAX_FANS) ? MAX_FANS : FAN_COUNT;

  typedef struct packed {
    logic [7:0]                 duty;
    logic                       failsafe;
    logic                       tevent;
    logic                       report;
    logic [MAX_FANS-1:0][15:0]  rpm;
  } fan_status_t;

  fan_status_t status_q[$];

  cfg_t        cfg;
  logic [15:0] pulse_cnt [MAX_FANS];
  logic [15:0] rpm_latch [MAX_FANS];
  logic [15:0] window_cnt;
  logic [15:0] quiet_ms;
  logic        fs_on;
  logic [7:0]  duty_now;
  int          n_bad = 0;

  assign mismatches = n_bad;

  function automatic logic [7:0] pct_duty(input int unsigned pct);
    int unsigned d;
    d = pct * 255 / 100;
    return (d > 255) ? 8'hFF : d[7:0];
  endfunction

  // Applies one word to the local copy of the controller state and returns the
  // status word that the block must report for it.
  function automatic fan_status_t advance_controller(input op_t op, input logic [4:0] mask,
                                                     input logic [7:0] pct);
    fan_status_t s;
    int unsigned prod;
    int unsigned next_quiet;
    int          f;
    s = '0;
    case (op)
      OP_TICK: begin
        if (window_cnt != CNT_MAX) window_cnt = window_cnt + 16'd1;
        if (window_cnt >= cfg.window_ms) begin
          for (f = 0; f < LANES; f++) begin
            prod = 32'(pulse_cnt[f]) * 32'(cfg.rpm_per_pulse);
            rpm_latch[f] = (prod > 32'hFFFF) ? CNT_MAX : prod[15:0];
            pulse_cnt[f] = '0;
          end
          window_cnt = '0;
        end
        // The timeout compare uses the count before it saturates.
        next_quiet = 32'(quiet_ms) + 1;
        quiet_ms = (next_quiet > 32'hFFFF) ? CNT_MAX : next_quiet[15:0];
        if (!fs_on && next_quiet > 32'(cfg.timeout_ms)) begin
          fs_on = 1'b1;
          duty_now = pct_duty(32'(cfg.failsafe_percent));
          s.tevent = 1'b1;
        end
      end
      OP_TACH: begin
        for (f = 0; f < LANES; f++) begin
          if (mask[f] && pulse_cnt[f] != CNT_MAX) pulse_cnt[f] = pulse_cnt[f] + 16'd1;
        end
      end
      OP_CMD: begin
        if (pct >= PCT_MIN && pct <= PCT_MAX) begin
          duty_now = pct_duty(32'(pct));
          quiet_ms = '0;
          fs_on = 1'b0;
          s.report = 1'b1;
        end
      end
      default: begin
      end
    endcase
    s.duty = duty_now;
    s.failsafe = fs_on;
    for (f = 0; f < MAX_FANS; f++) begin
      s.rpm[f] = (f < LANES) ? rpm_latch[f] : 16'd0;
    end
    return s;
  endfunction

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      n_bad++;
    end
  endtask

  always @(posedge clk) begin
    fan_status_t               want;
    logic [MAX_FANS-1:0][15:0] seen_rpm;
    if (rst) begin
      cfg.failsafe_percent = RST_FAILSAFE_PERCENT;
      cfg.timeout_ms = RST_TIMEOUT_MS;
      cfg.window_ms = RST_WINDOW_MS;
      cfg.rpm_per_pulse = RST_RPM_PER_PULSE;
      for (int f = 0; f < MAX_FANS; f++) begin
        pulse_cnt[f] = '0;
        rpm_latch[f] = '0;
      end
      window_cnt = '0;
      quiet_ms = '0;
      fs_on = 1'b1;
      duty_now = pct_duty(32'(RST_FAILSAFE_PERCENT));
      status_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_FAILSAFE_PERCENT: cfg.failsafe_percent = pwdata[6:0];
          REG_TIMEOUT_MS:       cfg.timeout_ms = pwdata[15:0];
          REG_WINDOW_MS:        cfg.window_ms = pwdata[15:0];
          REG_RPM_PER_PULSE:    cfg.rpm_per_pulse = pwdata[7:0];
          default: begin
          end
        endcase
      end
      if (result.valid && result.ready) begin
        if (status_q.size() == 0) begin
          $display("%0t: result word arrived with nothing expected, actual duty %0d",
                   $time, result.duty);
          n_bad++;
        end else begin
          want = status_q.pop_front();
          seen_rpm = {result.rpm_fan4, result.rpm_fan3, result.rpm_fan2,
                      result.rpm_fan1, result.rpm_fan0};
          compare_field("duty", want.duty, result.duty);
          compare_field("failsafe_active", want.failsafe, result.failsafe_active);
          compare_field("timeout_event", want.tevent, result.timeout_event);
          compare_field("report_valid", want.report, result.report_valid);
          for (int f = 0; f < MAX_FANS; f++) begin
            compare_field($sformatf("rpm_fan%0d", f), want.rpm[f], seen_rpm[f]);
          end
        end
      end
      if (item.valid && item.ready) begin
        status_q.push_back(advance_controller(op_t'(item.opcode), item.edge_mask,
                                              item.speed_percent));
      end
    end
    in_flight <= status_q.size();
  end

endmodule

/* tb/tb_fan_tach_rpm_and_failsafe_pwm.sv */
`timescale 1ns / 100ps
module tb_fan_tach_rpm_and_failsafe_pwm;
  import ftr_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASES = 6;
  localparam int WORDS_PER_PHASE = 100;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  bit                calm = 1'b0;
  int                mismatches;
  int                in_flight;
  int                quiet_cycles = 0;

  ftr_in_if  item_if ();
  ftr_out_if result_if ();

  fan_tach_rpm_and_failsafe_pwm DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_if),
    .result  (result_if)
  );

  ftr_status_check u_status_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .item       (item_if),
    .result     (result_if),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The result side stalls about 30 percent of the time unless calm is set.
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_if.ready <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
        psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input op_t op, input logic [4:0] mask, input logic [7:0] pct);
    while (!calm && $urandom_range(0, 99) < 30) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.opcode <= op;
    item_if.edge_mask <= mask;
    item_if.speed_percent <= pct;
    do @(posedge clk); while (!item_if.ready);
  endtask

  task automatic random_word();
    int          r;
    op_t         op;
    logic [7:0]  pct;
    r = $urandom_range(0, 99);
    op = (r < 40) ? OP_TICK : (r < 75) ? OP_TACH : (r < 95) ? OP_CMD : OP_IDLE;
    // Mostly legal percents, with the full byte range now and then.
    if ($urandom_range(0, 9) == 0) pct = 8'($urandom_range(0, 255));
    else pct = 8'($urandom_range(1, 100));
    send_word(op, 5'($urandom), pct);
  endtask

  // Waits until every expected word has come back, plus a short margin for
  // the two-stage pipeline.
  task automatic drain();
    item_if.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [6:0] fs, input logic [15:0] tmo,
                              input logic [15:0] win, input logic [7:0] rpp);
    logic [DATA_W-1:0] vals [4];
    vals[REG_FAILSAFE_PERCENT] = DATA_W'(fs);
    vals[REG_TIMEOUT_MS] = DATA_W'(tmo);
    vals[REG_WINDOW_MS] = DATA_W'(win);
    vals[REG_RPM_PER_PULSE] = DATA_W'(rpp);
    for (int i = 0; i < 4; i++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx_t'(i), 2'b00};
      pwdata <= vals[i];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    item_if.valid <= 1'b0;
    item_if.opcode <= OP_IDLE;
    item_if.edge_mask <= '0;
    item_if.speed_percent <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset state, then every opcode and the command range edges.
    send_word(OP_IDLE, 5'd0, 8'd0);
    send_word(OP_TICK, 5'd0, 8'd0);
    send_word(OP_TACH, 5'b11111, 8'd0);
    send_word(OP_TACH, 5'b10101, 8'd0);
    send_word(OP_CMD, 5'd0, 8'd0);
    send_word(OP_CMD, 5'd0, 8'd101);
    send_word(OP_CMD, 5'd0, 8'd255);
    send_word(OP_CMD, 5'd0, 8'd1);
    send_word(OP_CMD, 5'd0, 8'd100);
    send_word(OP_TACH, 5'b01010, 8'd0);
    send_word(OP_TICK, 5'd0, 8'd0);
    drain();

    // Window and timeout of one ms with the largest multiplier: a latch on every
    // tick and a timeout on the second tick after a command.
    write_config(7'd0, 16'd1, 16'd1, 8'd255);
    send_word(OP_CMD, 5'd0, 8'd50);
    repeat (3) send_word(OP_TACH, 5'b11111, 8'd0);
    send_word(OP_TICK, 5'd0, 8'd0);
    send_word(OP_TICK, 5'd0, 8'd0);
    send_word(OP_TICK, 5'd0, 8'd0);
    send_word(OP_CMD, 5'd0, 8'd100);
    drain();

    // Enough pulses in one window that every latched RPM saturates, sent back
    // to back with no idling on either side.
    write_config(7'd127, 16'hFFFF, 16'd1, 8'd255);
    send_word(OP_CMD, 5'd0, 8'd10);
    calm = 1'b1;
    repeat (260) send_word(OP_TACH, 5'b11111, 8'd0);
    calm = 1'b0;
    send_word(OP_TICK, 5'd0, 8'd0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) write_config(7'd100, 16'd1, 16'd1, 8'd255);
      else if (p == 1) write_config(7'd127, 16'd3, 16'd0, 8'd1);
      else write_config(7'($urandom_range(0, 127)), 16'($urandom_range(1, 30)),
                        16'($urandom_range(1, 12)), 8'($urandom_range(1, 255)));
      calm = (p == 3);
      repeat (WORDS_PER_PHASE) random_word();
      calm = 1'b0;
      drain();
    end

    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* fan_tach_rpm_and_failsafe_pwm.f */
sv/ftr_pkg.sv
sv/ftr_in_if.sv
sv/ftr_out_if.sv
sv/ftr_regs.sv
sv/ftr_tach.sv
sv/ftr_wdog.sv
sv/fan_tach_rpm_and_failsafe_pwm.sv
tb/ftr_status_check.sv
tb/tb_fan_tach_rpm_and_failsafe_pwm.sv
